### src/sfcs_pkg.sv
// Package with shared types and constants for the SPI flash command sequencer.
package sfcs_pkg;

    localparam logic [23:0] FLASH_LAST_ADDR_DEF = 24'h1FFFFF;

    localparam logic [7:0] CMD_FAST_READ = 8'h0B;
    localparam logic [7:0] CMD_RDSR      = 8'h05;
    localparam logic [7:0] CMD_EWSR      = 8'h50;
    localparam logic [7:0] CMD_WRSR      = 8'h01;
    localparam logic [7:0] CMD_WREN      = 8'h06;
    localparam logic [7:0] CMD_PROG      = 8'h02;
    localparam logic [7:0] CMD_ERASE     = 8'h60;
    localparam logic [7:0] CMD_JEDEC     = 8'h9F;
    localparam logic [7:0] CMD_LEGACY_ID = 8'h90;
    localparam logic [7:0] STATUS_BUSY   = 8'h03;
    localparam logic [7:0] DUMMY_BYTE    = 8'hFF;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_PROG  = 2'd1;
    localparam logic [1:0] OP_ERASE = 2'd2;
    localparam logic [1:0] OP_ID    = 2'd3;

    localparam logic [1:0] ID_JEDEC   = 2'd1;
    localparam logic [1:0] ID_INVALID = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE, PH_RD, PH_JEDEC, PH_LEGACY, PH_SAVE, PH_EWSR_CLR, PH_WRSR_CLR,
        PH_WREN_PROG, PH_PROG, PH_POLL, PH_WREN_TAIL, PH_EWSR_TAIL, PH_WRSR_TAIL,
        PH_WREN_ERASE, PH_ERASE
    } phase_t;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  op;
        logic [23:0] start_address;
        logic [24:0] byte_count;
        logic [1:0]  id_type;
        logic [7:0]  write_byte;
        logic        miso;
    } item_t;

    typedef struct packed {
        logic        cs_n;
        logic        mosi;
        logic        sck_pulse;
        logic        need_byte;
        logic        read_valid;
        logic [7:0]  read_byte;
        logic [23:0] id_value;
        logic        done_res;
        logic        ok;
        logic        busy_res;
    } result_t;

    function automatic logic [2:0] frame_len(input phase_t ph);
        case (ph)
            PH_RD, PH_LEGACY, PH_PROG: frame_len = 3'd5;
            PH_JEDEC: frame_len = 3'd4;
            PH_SAVE, PH_POLL, PH_WRSR_CLR, PH_WRSR_TAIL: frame_len = 3'd2;
            default: frame_len = 3'd1;
        endcase
    endfunction

endpackage

### src/sfcs_engine.sv
// Sequencer state and the per-period step logic feeding the result register.
module sfcs_engine
    import sfcs_pkg::*;
#(
    parameter logic [23:0] FLASH_LAST_ADDR = FLASH_LAST_ADDR_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output result_t res
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [23:0] cur_address_reg, cur_address_next;
    logic [24:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  saved_status_reg, saved_status_next;
    logic [23:0] id_accum_reg, id_accum_next;
    logic [3:0]  op_latched_reg, op_latched_next;
    logic [2:0]  byte_pos_reg, byte_pos_next;
    logic        in_gap_reg, in_gap_next;

    logic        prog;
    logic        src_tx;
    logic [7:0]  src_byte;
    logic [7:0]  sb;
    logic [25:0] last_sum;
    logic        good;
    logic        frame_end;
    phase_t      nxt;

    assign prog = (op_latched_reg[1:0] == OP_PROG);
    assign last_sum = {2'b0, item.start_address} + {1'b0, item.byte_count} - 26'd1;

    always_comb
    begin
        src_tx = 1'b1;
        src_byte = 8'h00;
        case (phase_reg)
            PH_RD, PH_PROG:
            begin
                case (byte_pos_reg)
                    3'd0: src_byte = (phase_reg == PH_RD) ? CMD_FAST_READ : CMD_PROG;
                    3'd1: src_byte = cur_address_reg[23:16];
                    3'd2: src_byte = cur_address_reg[15:8];
                    3'd3: src_byte = cur_address_reg[7:0];
                    3'd4: src_byte = (phase_reg == PH_RD) ? DUMMY_BYTE : item.write_byte;
                    default:
                    begin
                        src_byte = item.write_byte;
                        src_tx = (phase_reg == PH_PROG);
                    end
                endcase
            end
            PH_JEDEC:
            begin
                src_byte = CMD_JEDEC;
                src_tx = (byte_pos_reg == 3'd0);
            end
            PH_LEGACY:
            begin
                if (byte_pos_reg == 3'd0)
                    src_byte = CMD_LEGACY_ID;
                else if (byte_pos_reg == 3'd3)
                    src_byte = {6'd0, op_latched_reg[3:2]};
                src_tx = (byte_pos_reg < 3'd4);
            end
            PH_SAVE, PH_POLL:
            begin
                src_byte = CMD_RDSR;
                src_tx = (byte_pos_reg == 3'd0);
            end
            PH_EWSR_CLR, PH_EWSR_TAIL: src_byte = CMD_EWSR;
            PH_WRSR_CLR: src_byte = (byte_pos_reg == 3'd0) ? CMD_WRSR : 8'h00;
            PH_WRSR_TAIL: src_byte = (byte_pos_reg == 3'd0) ? CMD_WRSR : saved_status_reg;
            PH_WREN_PROG, PH_WREN_TAIL, PH_WREN_ERASE: src_byte = CMD_WREN;
            PH_ERASE: src_byte = CMD_ERASE;
            default: src_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        bit_index_next = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        cur_address_next = cur_address_reg;
        bytes_left_next = bytes_left_reg;
        saved_status_next = saved_status_reg;
        id_accum_next = id_accum_reg;
        op_latched_next = op_latched_reg;
        byte_pos_next = byte_pos_reg;
        in_gap_next = in_gap_reg;
        res = '0;
        res.cs_n = 1'b1;
        good = 1'b1;
        nxt = PH_IDLE;
        sb = 8'h00;
        frame_end = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            if (item.req_type)
            begin
                if ((item.op == OP_READ) || (item.op == OP_PROG))
                begin
                    if ((item.byte_count == 25'd0) || (last_sum > {2'b0, FLASH_LAST_ADDR}))
                        good = 1'b0;
                end
                if ((item.op == OP_ID) && (item.id_type == ID_INVALID))
                    good = 1'b0;
                if (!good)
                    res.done_res = 1'b1;
                else
                begin
                    op_latched_next = {item.id_type, item.op};
                    cur_address_next = item.start_address;
                    bytes_left_next = (item.op <= OP_PROG) ? item.byte_count : 25'd0;
                    id_accum_next = 24'd0;
                    bit_index_next = 3'd0;
                    byte_pos_next = 3'd0;
                    in_gap_next = 1'b0;
                    if (item.op == OP_READ)
                        phase_next = PH_RD;
                    else if (item.op == OP_ID)
                        phase_next = (item.id_type == ID_JEDEC) ? PH_JEDEC : PH_LEGACY;
                    else
                        phase_next = PH_SAVE;
                end
            end
        end
        else if (in_gap_reg)
        begin
            case (phase_reg)
                PH_SAVE: nxt = PH_EWSR_CLR;
                PH_EWSR_CLR: nxt = PH_WRSR_CLR;
                PH_WRSR_CLR: nxt = prog ? PH_WREN_PROG : PH_WREN_ERASE;
                PH_WREN_PROG: nxt = PH_PROG;
                PH_PROG: nxt = PH_POLL;
                PH_POLL:
                begin
                    if (shift_byte_reg == STATUS_BUSY)
                        nxt = PH_POLL;
                    else if (prog)
                    begin
                        bytes_left_next = bytes_left_reg - 25'd1;
                        cur_address_next = cur_address_reg + 24'd1;
                        nxt = (bytes_left_reg != 25'd1) ? PH_WREN_PROG : PH_WREN_TAIL;
                    end
                    else
                        nxt = PH_IDLE;
                end
                PH_WREN_TAIL: nxt = PH_EWSR_TAIL;
                PH_EWSR_TAIL: nxt = PH_WRSR_TAIL;
                PH_WREN_ERASE: nxt = PH_ERASE;
                PH_ERASE: nxt = PH_POLL;
                default: nxt = PH_IDLE;
            endcase
            if (nxt == PH_IDLE)
            begin
                res.done_res = 1'b1;
                res.ok = 1'b1;
                if ((phase_reg == PH_JEDEC) || (phase_reg == PH_LEGACY))
                    res.id_value = id_accum_reg;
            end
            phase_next = nxt;
            byte_pos_next = 3'd0;
            bit_index_next = 3'd0;
            in_gap_next = 1'b0;
        end
        else
        begin
            res.cs_n = 1'b0;
            res.sck_pulse = 1'b1;
            if (src_tx)
            begin
                sb = (bit_index_reg == 3'd0) ? src_byte : shift_byte_reg;
                res.mosi = sb[7];
                shift_byte_next = {sb[6:0], 1'b0};
            end
            else
                shift_byte_next = {shift_byte_reg[6:0], item.miso};
            bit_index_next = bit_index_reg + 3'd1;
            if (bit_index_reg == 3'd7)
            begin
                if (!src_tx)
                begin
                    if (phase_reg == PH_RD)
                    begin
                        res.read_valid = 1'b1;
                        res.read_byte = shift_byte_next;
                        bytes_left_next = bytes_left_reg - 25'd1;
                    end
                    else if ((phase_reg == PH_JEDEC) || (phase_reg == PH_LEGACY))
                        id_accum_next = {id_accum_reg[15:0], shift_byte_next};
                    else if ((phase_reg == PH_SAVE) && prog)
                        saved_status_next = shift_byte_next;
                end
                if (phase_reg == PH_RD)
                begin
                    if (byte_pos_reg < 3'd5)
                        byte_pos_next = byte_pos_reg + 3'd1;
                    else if (bytes_left_next == 25'd0)
                        frame_end = 1'b1;
                end
                else
                begin
                    byte_pos_next = byte_pos_reg + 3'd1;
                    if (byte_pos_next >= frame_len(phase_reg))
                        frame_end = 1'b1;
                end
                if (frame_end)
                    in_gap_next = 1'b1;
                else if ((phase_reg == PH_PROG) && (byte_pos_next == 3'd4))
                    res.need_byte = 1'b1;
            end
        end
        res.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bit_index_reg <= 3'd0;
            shift_byte_reg <= 8'd0;
            cur_address_reg <= 24'd0;
            bytes_left_reg <= 25'd0;
            saved_status_reg <= 8'd0;
            id_accum_reg <= 24'd0;
            op_latched_reg <= 4'd0;
            byte_pos_reg <= 3'd0;
            in_gap_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            bit_index_reg <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
            cur_address_reg <= cur_address_next;
            bytes_left_reg <= bytes_left_next;
            saved_status_reg <= saved_status_next;
            id_accum_reg <= id_accum_next;
            op_latched_reg <= op_latched_next;
            byte_pos_reg <= byte_pos_next;
            in_gap_reg <= in_gap_next;
        end
    end

endmodule

### src/spi_flash_command_sequencer_core.sv
// Top level of the SPI flash command sequencer with input and result registers.
//
// Channel  Dir  Contents
// s_axis   in   one bit-period tick or start request per transaction
// m_axis   out  one pin and status result per accepted transaction
//
// Each transaction is one SPI bit period; one is accepted every clock cycle unless the result side stalls.
// An input register feeds the step logic, whose result goes to a result register.
// A stalled result register holds the step logic, which stalls the input side.
// Reset returns the sequencer to idle and empties both registers.
module spi_flash_command_sequencer_core
    import sfcs_pkg::*;
#(
    parameter logic [23:0] FLASH_LAST_ADDR = FLASH_LAST_ADDR_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // op, start_address, byte_count, id_type,
                                       // write_byte, miso
    input  logic        s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // cs_n, mosi, sck_pulse, need_byte, read_valid,
                                       // read_byte, id_value, done_res, ok, busy_res
);

    item_t   in_reg;
    logic    in_valid_reg;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    step;

    assign step = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (step)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg.req_type <= s_axis_tuser;
            in_reg.op <= s_axis_tdata[1:0];
            in_reg.start_address <= s_axis_tdata[25:2];
            in_reg.byte_count <= s_axis_tdata[50:26];
            in_reg.id_type <= s_axis_tdata[52:51];
            in_reg.write_byte <= s_axis_tdata[60:53];
            in_reg.miso <= s_axis_tdata[61];
        end
        if (step)
            out_reg <= res;
    end

    sfcs_engine #(.FLASH_LAST_ADDR(FLASH_LAST_ADDR)) u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .step(step),
        .item(in_reg),
        .res(res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {out_reg.busy_res, out_reg.ok, out_reg.done_res, out_reg.id_value,
                           out_reg.read_byte, out_reg.read_valid, out_reg.need_byte,
                           out_reg.sck_pulse, out_reg.mosi, out_reg.cs_n};

endmodule
